@@ hdl/b32enc_pkg.sv @@
// Shared types, constants and symbol lookup for the base32 stream encoder.
package b32enc_pkg;

   // Width of one base32 group and the largest number of leftover bits
   localparam int unsigned GROUP_W      = 5;
   localparam int unsigned MAX_LEFTOVER = 4;
   localparam logic [7:0]  ASCII_LOWER_A = 8'h61;   // 'a'
   localparam logic [7:0]  ASCII_DIGIT_OFS = 8'h18; // '2' minus 26
   localparam logic [4:0]  LETTER_COUNT = 5'd26;

   // One input byte: up to three groups, how many are valid, and end of message
   typedef struct packed {
      logic [2:0][GROUP_W-1:0] groups;
      logic [1:0]              count;
      logic                    last;
   } job_type;

   // Map a 5-bit group to its lowercase base32 ASCII symbol
   function automatic logic [7:0] symbol_of(input logic [GROUP_W-1:0] group);
      logic [7:0] code;
      if (group < LETTER_COUNT) begin
         code = ASCII_LOWER_A + {3'b000, group};
      end else begin
         code = ASCII_DIGIT_OFS + {3'b000, group};
      end
      return code;
   endfunction

endpackage

@@ hdl/base32_stream_encoder.sv @@
// Top level of the base32 stream encoder: front end, job queue and symbol back end.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data_byte, req_end_of_message
//   rsp      out        rsp_valid/rsp_stall  rsp_symbol_char, rsp_last_symbol
//
// A byte is taken every cycle while the job queue has room; it becomes one to
// three symbols, and the back end sends one symbol per cycle while rsp_stall is
// low, so the sustained rate is set by the result port. A request passes through
// a job queue entry and then the output register before its first symbol appears.
// Synchronous reset clears the leftover bits, the queue and the output valid flag.
// req_stall rises only when the queue is full; rsp_stall holds the symbol in place.
module base32_stream_encoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_symbol_char,
   output logic       rsp_last_symbol
);
   import b32enc_pkg::*;

   job_type new_job;
   job_type head_job;
   logic    accept;
   logic    q_empty;
   logic    q_full;
   logic    pop;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   b32enc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .end_of_message (req_end_of_message),
      .job            (new_job)
   );

   b32enc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (new_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   b32enc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .empty           (q_empty),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_symbol_char (rsp_symbol_char),
      .rsp_last_symbol (rsp_last_symbol)
   );

endmodule

@@ hdl/b32enc_front.sv @@
// Front end: takes a byte, merges it with leftover bits and cuts it into groups.
module b32enc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 end_of_message,
   output b32enc_pkg::job_type  job
);
   import b32enc_pkg::*;

   logic [3:0]  leftover_bits_ff, leftover_bits_in;
   logic [2:0]  leftover_count_ff, leftover_count_in;
   logic [2:0]  cnt;
   logic [3:0]  cnt_mask;
   logic [11:0] acc;
   logic [3:0]  total;
   logic [3:0]  shift_amt;
   logic [14:0] window;
   logic        two_full;
   logic [2:0]  rem;
   logic [3:0]  rem_mask;
   logic        pad;

   // Clamp count and line up the bits, oldest first, at the top of a 15-bit window
   always_comb begin
      cnt       = (leftover_count_ff > 3'(MAX_LEFTOVER)) ? 3'(MAX_LEFTOVER)
                                                         : leftover_count_ff;
      cnt_mask  = 4'((5'd1 << cnt) - 5'd1);
      acc       = {leftover_bits_ff & cnt_mask, data_byte};
      total     = {1'b0, cnt} + 4'd8;
      shift_amt = 4'd15 - total;
      window    = 15'({3'b000, acc} << shift_amt);
      two_full  = (total >= 4'd10);
      rem       = two_full ? 3'(total - 4'd10) : 3'(total - 4'd5);
      rem_mask  = 4'((5'd1 << rem) - 5'd1);
      pad       = end_of_message && (rem != 3'd0);
   end

   // Job for the queue; zero fill below the data gives the pad symbol
   always_comb begin
      job.groups[0] = window[14:10];
      job.groups[1] = window[9:5];
      job.groups[2] = window[4:0];
      job.count     = (two_full ? 2'd2 : 2'd1) + {1'b0, pad};
      job.last      = end_of_message;
   end

   // Leftover state keeps the remainder of an accepted byte and clears at end of message
   always_comb begin
      leftover_bits_in  = leftover_bits_ff;
      leftover_count_in = leftover_count_ff;
      if (accept) begin
         if (end_of_message) begin
            leftover_bits_in  = '0;
            leftover_count_in = '0;
         end else begin
            leftover_bits_in  = acc[3:0] & rem_mask;
            leftover_count_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_bits_ff  <= '0;
         leftover_count_ff <= '0;
      end else begin
         leftover_bits_ff  <= leftover_bits_in;
         leftover_count_ff <= leftover_count_in;
      end
   end

endmodule

@@ hdl/b32enc_queue.sv @@
// Small job queue between the front end and the symbol back end.
module b32enc_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b32enc_pkg::job_type  push_job,
   input  logic                 pop,
   output b32enc_pkg::job_type  head_job,
   output logic                 empty,
   output logic                 full
);
   import b32enc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type              entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign head_job = entries_ff[rd_ptr_ff];

   // Pointer wrap and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hdl/b32enc_back.sv @@
// Back end: walks the groups of the head job and drives one symbol per cycle while not stalled.
module b32enc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  b32enc_pkg::job_type  head_job,
   input  logic                 empty,
   output logic                 pop,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_symbol_char,
   output logic                 rsp_last_symbol
);
   import b32enc_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic       final_group;

   // Output register takes a new symbol when the queue has a job and the register is empty or being taken
   always_comb begin
      load        = !empty && (!valid_ff || !rsp_stall);
      final_group = (idx_ff == head_job.count - 2'd1);
      pop         = load && final_group;
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         idx_in   = final_group ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
         char_in  = symbol_of(head_job.groups[idx_ff]);
         last_in  = head_job.last && final_group;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset needed
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_symbol_char = char_ff;
   assign rsp_last_symbol = last_ff;

endmodule

@@ hdl/b32enc_checker.sv @@
// Port-level checks for the base32 stream encoder, bound to the top level.
module b32enc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_symbol_char,
   input logic       rsp_last_symbol
);

   // Reset leaves both sides idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("not idle after reset");

   // A stalled symbol stays offered
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled symbol keeps its payload
   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_symbol_char) && $stable(rsp_last_symbol)))
      else $error("rsp payload changed while stalled");

   // Every symbol is from the lowercase base32 alphabet
   a_legal_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_symbol_char >= 8'h61 && rsp_symbol_char <= 8'h7a) ||
                     (rsp_symbol_char >= 8'h32 && rsp_symbol_char <= 8'h37)))
      else $error("symbol outside alphabet");

   // No symbol right after reset unless a request was offered during reset
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      ($past(reset) && !$past(req_valid)) |-> !rsp_valid)
      else $error("symbol without a request");

endmodule

bind base32_stream_encoder b32enc_checker u_b32enc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_symbol_char (rsp_symbol_char),
   .rsp_last_symbol (rsp_last_symbol)
);

@@ dv/tb_base32_stream_encoder.sv @@
// Self-checking testbench for the base32 stream encoder: directed, random, backpressure and sender-pause tests.
module tb_base32_stream_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CLOCK_PERIOD  = 12;
   localparam int unsigned RESET_CYCLES  = 10;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 20;   // pipeline plus a full job queue
   localparam int unsigned IDLE_PERCENT  = 14;
   localparam int unsigned RANDOM_ITEMS  = 190;

   // One expected symbol on the result channel
   typedef struct {
      logic [7:0] code;
      logic       last;
   } symbol_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_end_of_message;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_symbol_char;
   logic       rsp_last_symbol;

   // Encoder state as the predictor sees it
   logic [3:0] pend_bits;
   logic [2:0] pend_count;
   string      b32_alphabet = "abcdefghijklmnopqrstuvwxyz234567";

   symbol_type expected_symbols[$];
   int         error_count;
   int         bytes_sent;
   int         messages_sent;
   int         symbols_checked;
   int         cycle_count;
   int         hold_left;
   bit         idle_on;

   base32_stream_encoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_symbol_char    (rsp_symbol_char),
      .rsp_last_symbol    (rsp_last_symbol)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Queue one symbol for a 5-bit group
   function automatic void push_symbol(input int group, input logic last);
      symbol_type s;
      s.code = b32_alphabet[group & 31];
      s.last = last;
      expected_symbols.push_back(s);
   endfunction

   // Predict the symbols caused by one accepted byte and advance the state
   function automatic void encode_byte(input logic [7:0] data, input logic eom);
      int cnt;
      int acc;
      int total;
      cnt = (pend_count > 3'd4) ? 4 : int'(pend_count);
      acc = ((int'(pend_bits) & ((1 << cnt) - 1)) << 8) | int'(data);
      total = cnt + 8;
      while (total >= 5) begin
         total -= 5;
         push_symbol((acc >> total) & 31, eom && (total == 0));
      end
      acc &= (1 << total) - 1;
      if (eom) begin
         if (total > 0) begin
            push_symbol((acc << (5 - total)) & 31, 1'b1);
         end
         pend_bits  = 4'd0;
         pend_count = 3'd0;
      end else begin
         pend_bits  = acc[3:0];
         pend_count = total[2:0];
      end
   endfunction

   // Offer one request, with random gaps ahead of it, and predict on acceptance
   task automatic send_byte(input logic [7:0] data, input logic eom);
      @(negedge clock);
      while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_valid          <= 1'b0;
         req_data_byte      <= 8'($urandom_range(255));
         req_end_of_message <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_end_of_message <= eom;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      encode_byte(data, eom);
      bytes_sent++;
      if (eom) messages_sent++;
   endtask

   // Random byte, leaning on the extremes now and then
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(7);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // One whole message of random content
   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(pick_byte(), i == len - 1);
      end
   endtask

   // Stop offering and wait for every expected symbol, then let the design settle
   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (idle_on) begin
         rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each accepted symbol against the oldest expectation
   always @(posedge clock) begin
      symbol_type exp_sym;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_symbols.size() == 0) begin
            $error("unexpected symbol %h (last %b)", rsp_symbol_char, rsp_last_symbol);
            error_count++;
         end else begin
            exp_sym = expected_symbols.pop_front();
            if (rsp_symbol_char !== exp_sym.code) begin
               $error("symbol_char expected %h got %h", exp_sym.code, rsp_symbol_char);
               error_count++;
            end
            if (rsp_last_symbol !== exp_sym.last) begin
               $error("last_symbol expected %b got %b", exp_sym.last, rsp_last_symbol);
               error_count++;
            end
            symbols_checked++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Extremes, every leftover count at end of message, the no-leftover flush
   task automatic test_directed();
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'h01, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // five bytes: the last full symbol closes the message, no padding
      send_byte(8'h66, 1'b0);
      send_byte(8'h6F, 1'b0);
      send_byte(8'h6F, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h61, 1'b1);
      // all ones over five bytes hits the top of the alphabet
      for (int i = 0; i < 5; i++) send_byte(8'hFF, i == 4);
      wait_drain();
   endtask

   // Random messages, with a long stretch of no idling in the middle
   task automatic test_random_messages();
      int start;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_ITEMS) begin
         idle_on = !((bytes_sent - start >= 100) && (bytes_sent - start < 180));
         if ($urandom_range(9) == 0) begin
            send_message($urandom_range(1, 40));
         end else begin
            send_message($urandom_range(1, 12));
         end
      end
      idle_on = 1'b1;
      wait_drain();
   endtask

   // Receiver holds off long enough that the queue fills and stalls requests
   task automatic test_backpressure();
      idle_on   = 1'b0;
      hold_left = 80;
      send_message(30);
      idle_on = 1'b1;
      wait_drain();
   endtask

   // Sender pauses mid-message until everything is out, then finishes it
   task automatic test_sender_pause();
      send_byte(pick_byte(), 1'b0);
      send_byte(pick_byte(), 1'b0);
      send_byte(pick_byte(), 1'b0);
      wait_drain();
      send_byte(pick_byte(), 1'b0);
      send_byte(pick_byte(), 1'b1);
      wait_drain();
   endtask

   // Sequence
   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data_byte      = 8'h00;
      req_end_of_message = 1'b0;
      rsp_stall          = 1'b0;
      pend_bits          = 4'd0;
      pend_count         = 3'd0;
      error_count        = 0;
      bytes_sent         = 0;
      messages_sent      = 0;
      symbols_checked    = 0;
      cycle_count        = 0;
      hold_left          = 0;
      idle_on            = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_messages();
      test_backpressure();
      test_sender_pause();

      if (expected_symbols.size() != 0) begin
         $error("%0d expected symbols never arrived", expected_symbols.size());
         error_count++;
      end
      $display("Encoded %0d bytes in %0d messages, %0d symbols checked, %0d errors.",
               bytes_sent, messages_sent, symbols_checked, error_count);
      $display("Covered extremes, all flush lengths, random stalls and a full-queue hold-off.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
